[hw/rtl/fevc_pkg.sv]
// ----------------------------------------------------------------------------
// fevc_pkg
// Shared types and constants for the FIFO-eviction key-value cache.
// ----------------------------------------------------------------------------
package fevc_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int CAP_W    = 5;
  localparam int APB_AW   = 3;

  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  // Register indexes on the configuration port
  localparam logic REG_CAPACITY = 1'b0;

  // Command codes; code 3 is a no-op
  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_e;

  // One entry as seen on the table's read port
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [SLOT_W-1:0] rank;
  } tbl_rd_t;

  // Table update for one cycle
  typedef struct packed {
    logic              upd_val;
    logic [SLOT_W-1:0] upd_slot;
    logic              drop;
    logic [SLOT_W-1:0] drop_slot;
    logic              ins;
    logic [SLOT_W-1:0] ins_slot;
    logic [SLOT_W-1:0] ins_rank;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } tbl_wr_t;

  // One result beat
  typedef struct packed {
    logic               found;
    logic [DATA_W-1:0]  value_out;
    logic [COUNT_W-1:0] entry_count;
    logic               evicted;
    logic [DATA_W-1:0]  evicted_key;
  } result_t;

endpackage

[hw/rtl/fevc_table.sv]
// ----------------------------------------------------------------------------
// fevc_table
// Entry storage: keys, values, age ranks and valid bits, one read port.
// ----------------------------------------------------------------------------
module fevc_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [fevc_pkg::SLOT_W-1:0] rd_idx_i,
  output fevc_pkg::tbl_rd_t rd_o,
  input  fevc_pkg::tbl_wr_t wr_i
);
  import fevc_pkg::*;

  logic [DATA_W-1:0] keys_q   [CAPACITY];
  logic [DATA_W-1:0] values_q [CAPACITY];
  logic [SLOT_W-1:0] rank_q   [CAPACITY];
  logic [SLOT_W-1:0] rank_d   [CAPACITY];
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [SLOT_W-1:0] drop_rank;

  // Read the addressed entry
  always_comb begin
    rd_o.valid = valid_q[rd_idx_i];
    rd_o.key   = keys_q[rd_idx_i];
    rd_o.value = values_q[rd_idx_i];
    rd_o.rank  = rank_q[rd_idx_i];
  end

  assign drop_rank = rank_q[wr_i.drop_slot];

  // Drop closes the rank gap, insert then takes its slot as newest
  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < CAPACITY; i++) begin
      rank_d[i] = rank_q[i];
      if (wr_i.drop && valid_q[i] && (rank_q[i] > drop_rank)) begin
        rank_d[i] = rank_q[i] - SLOT_W'(1);
      end
    end
    if (wr_i.drop) begin
      valid_d[wr_i.drop_slot] = 1'b0;
    end
    if (wr_i.ins) begin
      valid_d[wr_i.ins_slot] = 1'b1;
      rank_d[wr_i.ins_slot]  = wr_i.ins_rank;
    end
  end

  // Hold valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Write key, value and rank payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      rank_q[i] <= rank_d[i];
    end
    if (wr_i.ins) begin
      keys_q[wr_i.ins_slot]   <= wr_i.key;
      values_q[wr_i.ins_slot] <= wr_i.value;
    end
    if (wr_i.upd_val) begin
      values_q[wr_i.upd_slot] <= wr_i.value;
    end
  end

endmodule

[hw/rtl/fevc_ctrl.sv]
// ----------------------------------------------------------------------------
// fevc_ctrl
// Sequencer: scans the table with one shared key comparator, then applies
// the put, get or remove in the update state.
// ----------------------------------------------------------------------------
module fevc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [fevc_pkg::CAP_W-1:0]  cap_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  cmd_i,
  input  logic [fevc_pkg::DATA_W-1:0] key_i,
  input  logic [fevc_pkg::DATA_W-1:0] value_i,
  output logic [fevc_pkg::SLOT_W-1:0] rd_idx_o,
  input  fevc_pkg::tbl_rd_t           rd_i,
  output fevc_pkg::tbl_wr_t           wr_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output fevc_pkg::result_t           res_o
);
  import fevc_pkg::*;

  state_e state_q, state_d;
  logic [SLOT_W-1:0]  idx_q, idx_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [1:0]         cmd_q;
  logic [DATA_W-1:0]  key_q, value_q;
  logic               hit_q, hit_d, free_q, free_d, old_q, old_d;
  logic [SLOT_W-1:0]  hit_slot_q, hit_slot_d, free_slot_q, free_slot_d;
  logic [SLOT_W-1:0]  old_slot_q, old_slot_d;
  logic [DATA_W-1:0]  hit_val_q, hit_val_d, old_key_q, old_key_d;
  result_t            res_q, res_d;
  logic               key_eq, need_ev, use_old;
  logic [COUNT_W-1:0] eff_cap, count_ev;
  logic               accept;

  assign accept = in_valid_i && in_ready_o;

  // Clamp the capacity register into 1..CAPACITY
  always_comb begin
    if (cap_i == '0) begin
      eff_cap = COUNT_W'(1);
    end else if (COUNT_W'(cap_i) > COUNT_W'(CAPACITY)) begin
      eff_cap = COUNT_W'(CAPACITY);
    end else begin
      eff_cap = COUNT_W'(cap_i);
    end
  end

  // Shared comparator
  assign key_eq   = rd_i.key == key_q;
  assign rd_idx_o = idx_q;

  assign need_ev  = (count_q >= eff_cap) && old_q;
  assign use_old  = need_ev && (!free_q || (old_slot_q < free_slot_q));
  assign count_ev = need_ev ? count_q - COUNT_W'(1) : count_q;

  // Next state, scan captures and table update
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    hit_val_d   = hit_val_q;
    free_d      = free_q;
    free_slot_d = free_slot_q;
    old_d       = old_q;
    old_slot_d  = old_slot_q;
    old_key_d   = old_key_q;
    res_d       = res_q;
    wr_o        = '0;
    wr_o.key    = key_q;
    wr_o.value  = value_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          old_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_i.valid && key_eq && !hit_q) begin
          hit_d      = 1'b1;
          hit_slot_d = idx_q;
          hit_val_d  = rd_i.value;
        end
        if (!rd_i.valid && !free_q) begin
          free_d      = 1'b1;
          free_slot_d = idx_q;
        end
        if (rd_i.valid && (rd_i.rank == '0) && !old_q) begin
          old_d      = 1'b1;
          old_slot_d = idx_q;
          old_key_d  = rd_i.key;
        end
        idx_d = idx_q + SLOT_W'(1);
        if (idx_q == SLOT_W'(CAPACITY - 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        res_d.found       = 1'b0;
        res_d.value_out   = MISS_VALUE;
        res_d.evicted     = 1'b0;
        res_d.evicted_key = '0;
        case (cmd_q)
          CMD_PUT: begin
            if (hit_q) begin
              res_d.found   = 1'b1;
              wr_o.upd_val  = 1'b1;
              wr_o.upd_slot = hit_slot_q;
            end else begin
              if (need_ev) begin
                res_d.evicted     = 1'b1;
                res_d.evicted_key = old_key_q;
                wr_o.drop         = 1'b1;
                wr_o.drop_slot    = old_slot_q;
              end
              if (need_ev || free_q) begin
                wr_o.ins      = 1'b1;
                wr_o.ins_slot = use_old ? old_slot_q : free_slot_q;
                wr_o.ins_rank = count_ev[SLOT_W-1:0];
                count_d       = count_ev + COUNT_W'(1);
              end else begin
                count_d = count_ev;
              end
            end
          end
          CMD_GET: begin
            if (hit_q) begin
              res_d.found     = 1'b1;
              res_d.value_out = hit_val_q;
            end
          end
          CMD_REMOVE: begin
            if (hit_q) begin
              res_d.found    = 1'b1;
              wr_o.drop      = 1'b1;
              wr_o.drop_slot = hit_slot_q;
              count_d        = count_q - COUNT_W'(1);
            end
          end
          default: begin
          end
        endcase
        res_d.entry_count = count_d;
        state_d           = ST_RESP;
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = res_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      old_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
      old_q   <= old_d;
    end
  end

  // Capture the input beat and scan payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    hit_slot_q  <= hit_slot_d;
    hit_val_q   <= hit_val_d;
    free_slot_q <= free_slot_d;
    old_slot_q  <= old_slot_d;
    old_key_q   <= old_key_d;
    res_q       <= res_d;
  end

endmodule

[hw/rtl/fifo_eviction_key_value_cache.sv]
// ----------------------------------------------------------------------------
// fifo_eviction_key_value_cache
// A 16-entry key-value cache with oldest-first eviction. Each input beat is a
// put, get or remove and yields exactly one result beat carrying hit status,
// the looked-up value (-1 on a miss or for put/remove), the entry count after
// the operation and the key of any evicted entry. Each operation runs, before
// the next beat is accepted, through the idle state that accepts the beat, a
// scan of the table through one shared key comparator, an update state and a
// state that hands the result to the output register. The block holds one
// result in its output register while it starts the next item.
// The capacity register (address 0) limits entries in use; 0 acts as 1 and
// values above 16 act as 16. The user must write it only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fifo_eviction_key_value_cache (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fevc_pkg::APB_AW-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         cmd_i,
  input  logic signed [fevc_pkg::DATA_W-1:0] key_i,
  input  logic signed [fevc_pkg::DATA_W-1:0] value_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               found_o,
  output logic signed [fevc_pkg::DATA_W-1:0] value_out_o,
  output logic [fevc_pkg::COUNT_W-1:0]       entry_count_o,
  output logic                               evicted_o,
  output logic signed [fevc_pkg::DATA_W-1:0] evicted_key_o
);
  import fevc_pkg::*;

  logic [CAP_W-1:0]  cap_q;
  logic [SLOT_W-1:0] rd_idx;
  tbl_rd_t           rd;
  tbl_wr_t           wr;
  logic              res_valid, res_ready;
  result_t           res;
  logic              out_valid_q;
  result_t           out_q;
  logic              reg_sel;

  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAPACITY);
    end else if (psel && penable && pwrite && (reg_sel == REG_CAPACITY)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (reg_sel == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_q} : '0;

  fevc_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd),
    .wr_i     (wr)
  );

  fevc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd),
    .wr_o        (wr),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load a new beat when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_q.found;
  assign value_out_o   = out_q.value_out;
  assign entry_count_o = out_q.entry_count;
  assign evicted_o     = out_q.evicted;
  assign evicted_key_o = out_q.evicted_key;

endmodule

[dv/kv_cache_tb_pkg.sv]
// ----------------------------------------------------------------------------
// kv_cache_tb_pkg
// Scoreboard for the FIFO-eviction key-value cache. It keeps its own copy of
// the entry table, works out the result of every accepted command beat and
// compares each result beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package kv_cache_tb_pkg;

  import fevc_pkg::*;

  // Command code with no operation behind it
  localparam logic [1:0] CMD_NOP = 2'd3;
  // Longest idle stretch either side draws per beat
  localparam int unsigned GAP_MAX = 12;

  class kv_cache_scoreboard;

    logic [DATA_W-1:0] slot_key [CAPACITY];
    logic [DATA_W-1:0] slot_val [CAPACITY];
    bit                slot_used [CAPACITY];
    int unsigned       slot_age [CAPACITY];
    int unsigned       used_count;
    logic [CAP_W-1:0]  cap_reg;
    result_t           expected_q [$];
    int unsigned       errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_val[i]  = '0;
        slot_age[i]  = 0;
      end
      used_count = 0;
      cap_reg    = CAP_W'(16);
      errors     = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      cap_reg = v;
    endfunction

    // Clamp the register to 1..CAPACITY
    function int unsigned allowed_entries();
      int unsigned c;
      c = cap_reg;
      if (c < 1) c = 1;
      if (c > CAPACITY) c = CAPACITY;
      return c;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function int find_key(logic [DATA_W-1:0] k);
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_used[i] && slot_key[i] == k) return i;
      end
      return -1;
    endfunction

    // Free a slot and close the hole it leaves in the age order
    function void release_slot(int s);
      int unsigned gone_age;
      gone_age     = slot_age[s];
      slot_used[s] = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_used[i] && slot_age[i] > gone_age) slot_age[i]--;
      end
      if (used_count > 0) used_count--;
    endfunction

    // Predict the result of one accepted command beat
    function void note_item(logic [1:0] op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
      result_t r;
      int      s;
      int      oldest;
      r.found       = 1'b0;
      r.value_out   = MISS_VALUE;
      r.evicted     = 1'b0;
      r.evicted_key = '0;
      s = find_key(k);
      if (op == CMD_PUT) begin
        if (s >= 0) begin
          r.found     = 1'b1;
          slot_val[s] = v;
        end else begin
          // full: drop the single oldest entry first
          if (used_count >= allowed_entries()) begin
            oldest = -1;
            for (int i = 0; i < CAPACITY; i++) begin
              if (oldest < 0 && slot_used[i] && slot_age[i] == 0) oldest = i;
            end
            if (oldest >= 0) begin
              r.evicted     = 1'b1;
              r.evicted_key = slot_key[oldest];
              release_slot(oldest);
            end
          end
          // insert as newest in the lowest free slot
          for (int i = 0; i < CAPACITY; i++) begin
            if (!slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_key[i]  = k;
              slot_val[i]  = v;
              slot_age[i]  = used_count;
              used_count++;
              break;
            end
          end
        end
      end else if (op == CMD_GET) begin
        if (s >= 0) begin
          r.found     = 1'b1;
          r.value_out = slot_val[s];
        end
      end else if (op == CMD_REMOVE) begin
        if (s >= 0) begin
          r.found = 1'b1;
          release_slot(s);
        end
      end
      r.entry_count = COUNT_W'(used_count);
      expected_q.push_back(r);
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none outstanding: found %0d value %0h count %0d",
                 $time, got.found, got.value_out, got.entry_count);
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found) begin
        errors++;
        $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
      end
      if (got.value_out !== want.value_out) begin
        errors++;
        $display("%0t: value_out expected %08h actual %08h", $time, want.value_out,
                 got.value_out);
      end
      if (got.entry_count !== want.entry_count) begin
        errors++;
        $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                 got.entry_count);
      end
      if (got.evicted !== want.evicted) begin
        errors++;
        $display("%0t: evicted expected %0d actual %0d", $time, want.evicted, got.evicted);
      end
      if (got.evicted_key !== want.evicted_key) begin
        errors++;
        $display("%0t: evicted_key expected %08h actual %08h", $time, want.evicted_key,
                 got.evicted_key);
      end
    endfunction

  endclass

endpackage

[dv/tb_fifo_eviction_key_value_cache.sv]
// ----------------------------------------------------------------------------
// tb_fifo_eviction_key_value_cache
// Drives put, get, remove and no-op beats into the cache under a range of
// capacity settings, with random idling on both channels and one long output
// stall, and checks every result beat against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_fifo_eviction_key_value_cache;

  timeunit 1ns;
  timeprecision 1ps;

  import fevc_pkg::*;
  import kv_cache_tb_pkg::*;

  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam logic [DATA_W-1:0] KEY_MIN   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] KEY_MAX   = 32'h7fff_ffff;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [1:0]          cmd_i       = '0;
  logic [DATA_W-1:0]   key_i       = '0;
  logic [DATA_W-1:0]   value_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                found_o;
  logic [DATA_W-1:0]   value_out_o;
  logic [COUNT_W-1:0]  entry_count_o;
  logic                evicted_o;
  logic [DATA_W-1:0]   evicted_key_o;

  kv_cache_scoreboard sb = new();

  bit          hold_req     = 1'b0;
  bit          send_calm    = 1'b0;
  int unsigned send_count   = 0;
  int unsigned quiet_cycles = 0;

  fifo_eviction_key_value_cache dut (.*);

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // End the run if no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fifo_eviction_key_value_cache: mismatch");
      $finish;
    end
  end

  // Offer one command beat and hold it until accepted
  task automatic send_item(input logic [1:0] op, input logic [DATA_W-1:0] k,
                           input logic [DATA_W-1:0] v);
    int unsigned gap;
    if (send_count % 32 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    key_i      <= k;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(op, k, v);
    send_count++;
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle
  task automatic end_phase();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup and access cycle on the register port
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_capacity(v);
  endtask

  // Random commands over a key pool a little larger than the capacity
  task automatic run_random_phase(input int unsigned n_items);
    logic [DATA_W-1:0] pool [$];
    int unsigned       pool_size;
    int unsigned       pick;
    logic [1:0]        op;
    logic [DATA_W-1:0] k;
    logic [DATA_W-1:0] v;
    pool_size = sb.allowed_entries() + $urandom_range(1, 8);
    for (int i = 0; i < pool_size; i++) pool.push_back($urandom);
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) op = CMD_PUT;
      else if (pick < 78) op = CMD_GET;
      else if (pick < 95) op = CMD_REMOVE;
      else op = CMD_NOP;
      k = ($urandom_range(0, 9) == 0) ? DATA_W'($urandom)
                                      : pool[$urandom_range(0, pool.size() - 1)];
      v = ($urandom_range(0, 19) == 0) ? MISS_VALUE : DATA_W'($urandom);
      send_item(op, k, v);
    end
    end_phase();
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned pause;
    int unsigned taken;
    bit          calm;
    result_t     got;
    taken = 0;
    calm  = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      if (hold_req) begin
        pause    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        pause = calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (pause > 0) begin
        out_ready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.found       = found_o;
      got.value_out   = value_out_o;
      got.entry_count = entry_count_o;
      got.evicted     = evicted_o;
      got.evicted_key = evicted_key_o;
      sb.check_result(got);
      taken++;
    end
  end

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [9];
    phase_caps = '{5'd16, 5'd2, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16, 5'd0};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store: misses and the unused code
    send_item(CMD_GET, 32'd5, 32'd0);
    send_item(CMD_REMOVE, 32'd5, 32'd0);
    send_item(CMD_NOP, 32'd5, 32'd9);
    // extremes of key and value
    send_item(CMD_PUT, KEY_MIN, KEY_MAX);
    send_item(CMD_PUT, KEY_MAX, KEY_MIN);
    send_item(CMD_PUT, '0, '0);
    send_item(CMD_PUT, '1, '1);
    send_item(CMD_GET, KEY_MIN, '0);
    send_item(CMD_GET, KEY_MAX, '0);
    send_item(CMD_GET, '1, '0);
    // overwrite keeps the entry's age
    send_item(CMD_PUT, KEY_MIN, 32'h0000_5a5a);
    send_item(CMD_GET, KEY_MIN, '0);
    // remove a present key, then the same key again
    send_item(CMD_REMOVE, '0, '0);
    send_item(CMD_REMOVE, '0, '0);
    send_item(CMD_GET, '0, '0);
    end_phase();

    // capacity below the count: each new key evicts only the oldest
    write_capacity('0);
    send_item(CMD_PUT, 32'd7, 32'd70);
    send_item(CMD_PUT, 32'd8, 32'd80);
    send_item(CMD_GET, KEY_MIN, '0);
    send_item(CMD_PUT, 32'd7, 32'd71);
    end_phase();

    // random phases across capacity settings, one with a long output stall
    for (int p = 0; p < 9; p++) begin
      if (p == 8) phase_caps[p] = CAP_W'($urandom_range(0, 31));
      write_capacity(phase_caps[p]);
      if (p == 1) hold_req = 1'b1;
      run_random_phase(ITEMS_PER_PHASE);
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("fifo_eviction_key_value_cache: match");
    end else begin
      $display("fifo_eviction_key_value_cache: mismatch");
    end
    $finish;
  end

endmodule
